// ===== src/minimum_jerk_trajectory_top_macros.svh =====
// Assertion helpers for the minimum-jerk trajectory block.
// Each macro expects clk and arst_n to exist in the scope where it is used.
`ifndef MINIMUM_JERK_TRAJECTORY_TOP_MACROS_SVH
`define MINIMUM_JERK_TRAJECTORY_TOP_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define MJT_ASSERT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define MJT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/mjt_pkg.sv =====
`default_nettype none

package mjt_pkg;

	// Default data format: Q16.16 in 32 bits.
	localparam int unsigned DATA_WIDTH = 32;
	localparam int unsigned FRAC_BITS  = 16;

	// Configuration register map.
	localparam int unsigned CFG_IDX_W = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_START    = 2'd0,
		REG_GOAL     = 2'd1,
		REG_DURATION = 2'd2
	} cfg_reg_t;

	// Quintic blend 10s^3 - 15s^4 + 6s^5 and its derivative 30s^2 - 60s^3 + 30s^4.
	localparam int COEF_BLEND3 = 10;
	localparam int COEF_BLEND4 = 15;
	localparam int COEF_BLEND5 = 6;
	localparam int COEF_RATE2  = 30;
	localparam int COEF_RATE3  = 60;
	localparam int COEF_RATE4  = 30;

endpackage

`default_nettype wire

// ===== src/mjt_in_if.sv =====
`default_nettype none

interface mjt_in_if #(
	parameter int unsigned DATA_WIDTH = mjt_pkg::DATA_WIDTH
);
	logic                  valid;
	logic                  ready;
	logic [DATA_WIDTH-1:0] elapsed_time;

	modport source(output valid, output elapsed_time, input ready);
	modport sink(input valid, input elapsed_time, output ready);
endinterface

`default_nettype wire

// ===== src/mjt_out_if.sv =====
`default_nettype none

interface mjt_out_if #(
	parameter int unsigned DATA_WIDTH = mjt_pkg::DATA_WIDTH
);
	logic                         valid;
	logic                         ready;
	logic signed [DATA_WIDTH-1:0] position_out;
	logic signed [DATA_WIDTH-1:0] velocity_out;

	modport source(output valid, output position_out, output velocity_out, input ready);
	modport sink(input valid, input position_out, input velocity_out, output ready);
endinterface

`default_nettype wire

// ===== src/mjt_cfg_if.sv =====
`default_nettype none

interface mjt_cfg_if #(
	parameter int unsigned DATA_WIDTH = mjt_pkg::DATA_WIDTH
);
	logic                           valid;
	logic                           ready;
	logic [mjt_pkg::CFG_IDX_W-1:0]  index;
	logic [DATA_WIDTH-1:0]          data;

	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== src/mjt_div_pipe.sv =====
`default_nettype none

// Pipelined restoring divider: one quotient bit per stage. The starting remainder
// must be below the divisor; the numerator bits are shifted in MSB first. The user
// must hold the divisor static while items are in flight; the block does not check.
module mjt_div_pipe #(
	parameter int unsigned DEN_W  = mjt_pkg::DATA_WIDTH,
	parameter int unsigned STEPS  = mjt_pkg::FRAC_BITS,
	parameter int unsigned SIDE_W = 1
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	input  wire logic              in_valid,
	input  wire logic [DEN_W-1:0]  in_rem,
	input  wire logic [STEPS-1:0]  in_bits,
	input  wire logic [SIDE_W-1:0] in_side,
	input  wire logic [DEN_W-1:0]  den,
	output logic                   out_valid,
	output logic [STEPS-1:0]       out_quo,
	output logic [SIDE_W-1:0]      out_side
);

	logic [STEPS-1:0]  valid_s;
	logic [DEN_W-1:0]  rem_s  [STEPS];
	logic [STEPS-1:0]  bits_s [STEPS];
	logic [STEPS-1:0]  quo_s  [STEPS];
	logic [SIDE_W-1:0] side_s [STEPS];

	logic [DEN_W-1:0]  rem_nx  [STEPS];
	logic [STEPS-1:0]  bits_nx [STEPS];
	logic [STEPS-1:0]  quo_nx  [STEPS];

	// One compare-and-subtract per stage, fed by the inputs or the previous stage's registers.
	always_comb begin
		logic [DEN_W-1:0] prev_rem;
		logic [STEPS-1:0] prev_bits;
		logic [STEPS-1:0] prev_quo;
		logic [DEN_W:0]   trial;
		logic [DEN_W:0]   diff;
		logic             take;
		for (int k = 0; k < STEPS; k++) begin
			if (k == 0) begin
				prev_rem  = in_rem;
				prev_bits = in_bits;
				prev_quo  = '0;
			end else begin
				prev_rem  = rem_s[k-1];
				prev_bits = bits_s[k-1];
				prev_quo  = quo_s[k-1];
			end
			trial      = {prev_rem, prev_bits[STEPS-1]};
			diff       = trial - {1'b0, den};
			take       = (trial >= {1'b0, den});
			rem_nx[k]  = take ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
			bits_nx[k] = {prev_bits[STEPS-2:0], 1'b0};
			quo_nx[k]  = {prev_quo[STEPS-2:0], take};
		end
	end

	// Valid bits travel with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= '0;
		end else if (en) begin
			valid_s <= {valid_s[STEPS-2:0], in_valid};
		end
	end

	// Stage payload.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < STEPS; k++) begin
				rem_s[k]  <= rem_nx[k];
				bits_s[k] <= bits_nx[k];
				quo_s[k]  <= quo_nx[k];
				if (k == 0) begin
					side_s[k] <= in_side;
				end else begin
					side_s[k] <= side_s[k-1];
				end
			end
		end
	end

	assign out_valid = valid_s[STEPS-1];
	assign out_quo   = quo_s[STEPS-1];
	assign out_side  = side_s[STEPS-1];

endmodule

`default_nettype wire

// ===== src/minimum_jerk_trajectory_top.sv =====
// Minimum-jerk trajectory sampler. Software writes start position, goal position and
// duration (signed, signed, unsigned fixed point with FRAC_BITS fraction bits; a
// duration of zero acts as one LSB), and each elapsed-time sample on the input channel
// yields one beat with position = start + (goal-start)*(10s^3-15s^4+6s^5) and velocity
// = (goal-start)*(30s^2-60s^3+30s^4)/duration, where s = elapsed/duration held at 1.0
// past the end; magnitudes truncate toward zero and both outputs saturate. The block
// is a fixed pipeline that takes one sample every cycle while no finished result is
// stalled at the output. Its two bit-per-stage dividers have FRAC_BITS stages for the
// phase and DATA_WIDTH stages for the velocity; the default data format is Q16.16. Input
// ready falls only while a finished result waits at the output. The configuration
// channel is always ready and its writes are meant for times when no sample is in
// flight; writes to an unknown index are dropped.
`default_nettype none

module minimum_jerk_trajectory_top #(
	parameter int unsigned DATA_WIDTH = mjt_pkg::DATA_WIDTH,
	parameter int unsigned FRAC_BITS  = mjt_pkg::FRAC_BITS
) (
	input  wire logic clk,
	input  wire logic arst_n,
	mjt_cfg_if.sink   cfg,
	mjt_in_if.sink    sample,
	mjt_out_if.source result
);

	localparam int unsigned W   = DATA_WIDTH;
	localparam int unsigned F   = FRAC_BITS;
	localparam int unsigned QW  = F + 1;          // phase and its powers, up to 1.0
	localparam int unsigned PW  = F + 6;          // rate polynomial, below 64.0
	localparam int unsigned BW  = F + 8;          // signed polynomial sums
	localparam int unsigned PPW = W + F + 2;      // |d| * blend
	localparam int unsigned VPW = W + F + 7;      // |d| * poly
	localparam int unsigned HW  = VPW - W;        // upper part of the velocity product
	localparam int unsigned CW  = (HW > W) ? HW : W;
	localparam int          ONE_Q = 1 << F;

	localparam logic signed [BW-1:0] ONE_X = BW'(ONE_Q);
	localparam logic signed [BW-1:0] K_B3  = BW'(mjt_pkg::COEF_BLEND3);
	localparam logic signed [BW-1:0] K_B4  = BW'(mjt_pkg::COEF_BLEND4);
	localparam logic signed [BW-1:0] K_B5  = BW'(mjt_pkg::COEF_BLEND5);
	localparam logic signed [BW-1:0] K_R2  = BW'(mjt_pkg::COEF_RATE2);
	localparam logic signed [BW-1:0] K_R3  = BW'(mjt_pkg::COEF_RATE3);
	localparam logic signed [BW-1:0] K_R4  = BW'(mjt_pkg::COEF_RATE4);

	localparam logic [W-1:0] SAT_MAX = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0] SAT_MIN = {1'b1, {(W-1){1'b0}}};

	// Fixed-point product of two phase powers, truncated.
	function automatic logic [QW-1:0] qmul(input logic [QW-1:0] a, input logic [QW-1:0] b);
		logic [2*QW-1:0] p;
		p = (2*QW)'(a) * (2*QW)'(b);
		return p[F +: QW];
	endfunction

	// Configuration registers and values derived from them.
	logic [W-1:0] start_position_q;
	logic [W-1:0] goal_position_q;
	logic [W-1:0] duration_time_q;
	logic [W-1:0] den_q;
	logic [W:0]   dmag_q;
	logic         dneg_q;
	logic [W:0]   diff_w;

	// Pipeline control.
	logic en;
	logic out_valid_q;
	logic [W-1:0] position_q;
	logic [W-1:0] velocity_q;

	// Stage registers.
	logic          v_s0, v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic [W-1:0]  t_s0;
	logic          full_s0;
	logic [QW-1:0] s_s1, s_s2, s_s3;
	logic [QW-1:0] p2_s1, p2_s2, p2_s3, p2_s4;
	logic [QW-1:0] p3_s2, p3_s3, p3_s4;
	logic [QW-1:0] p4_s3, p4_s4;
	logic [QW-1:0] p5_s4;
	logic [QW-1:0] blend_s5;
	logic [PW-1:0] poly_s5;
	logic [PPW-1:0] pprod_s6;
	logic [VPW-1:0] vprod_s6;
	logic [W-1:0]  pos_s7;
	logic          ovf_s7;
	logic [W-1:0]  rem_s7;
	logic [W-1:0]  low_s7;

	// Divider outputs.
	logic          ph_valid;
	logic [F-1:0]  ph_quo;
	logic          ph_full;
	logic [QW-1:0] phase;
	logic          vd_valid;
	logic [W-1:0]  vd_quo;
	logic [W:0]    vd_side;

	// Combinational stage logic.
	logic [QW-1:0] blend_nx;
	logic [PW-1:0] poly_nx;
	logic [W-1:0]  pos_nx;
	logic [HW-1:0] vhi;
	logic          ovf_nx;
	logic [W-1:0]  vel_nx;

	// The whole pipeline moves unless a finished result is stalled.
	assign en           = !out_valid_q || result.ready;
	assign sample.ready = en;
	assign cfg.ready    = 1'b1;

	// Register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_position_q <= '0;
			goal_position_q  <= '0;
			duration_time_q  <= W'(ONE_Q);
		end else if (cfg.valid) begin
			case (mjt_pkg::cfg_reg_t'(cfg.index))
				mjt_pkg::REG_START:    start_position_q <= cfg.data;
				mjt_pkg::REG_GOAL:     goal_position_q  <= cfg.data;
				mjt_pkg::REG_DURATION: duration_time_q  <= cfg.data;
				default: ;
			endcase
		end
	end

	// Effective divisor and the sign and magnitude of goal - start.
	assign diff_w = {goal_position_q[W-1], goal_position_q}
		- {start_position_q[W-1], start_position_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			den_q  <= W'(ONE_Q);
			dmag_q <= '0;
			dneg_q <= 1'b0;
		end else begin
			den_q  <= (duration_time_q == '0) ? W'(1) : duration_time_q;
			dneg_q <= diff_w[W];
			dmag_q <= diff_w[W] ? ((W+1)'(0) - diff_w) : diff_w;
		end
	end

	// Valid bits of the stages outside the dividers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s0        <= 1'b0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			v_s5        <= 1'b0;
			v_s6        <= 1'b0;
			v_s7        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			v_s0        <= sample.valid;
			v_s1        <= ph_valid;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			v_s4        <= v_s3;
			v_s5        <= v_s4;
			v_s6        <= v_s5;
			v_s7        <= v_s6;
			out_valid_q <= vd_valid;
		end
	end

	// Input register; samples at or past the duration take the phase 1.0.
	// The compare reads the duration register itself, so a sample right after a write
	// sees the new value; a zero duration acts as one LSB, where any nonzero time is past
	// the end.
	always_ff @(posedge clk) begin
		if (en) begin
			t_s0    <= sample.elapsed_time;
			full_s0 <= (sample.elapsed_time >= duration_time_q)
				&& (sample.elapsed_time != '0);
		end
	end

	// Phase s = t / duration, F fraction bits.
	mjt_div_pipe #(
		.DEN_W  (W),
		.STEPS  (F),
		.SIDE_W (1)
	) u_phase_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s0),
		.in_rem    (full_s0 ? '0 : t_s0),
		.in_bits   ('0),
		.in_side   (full_s0),
		.den       (den_q),
		.out_valid (ph_valid),
		.out_quo   (ph_quo),
		.out_side  (ph_full)
	);

	assign phase = ph_full ? QW'(ONE_Q) : {1'b0, ph_quo};

	// Powers of the phase, one multiply per stage.
	always_ff @(posedge clk) begin
		if (en) begin
			s_s1  <= phase;
			p2_s1 <= qmul(phase, phase);

			s_s2  <= s_s1;
			p2_s2 <= p2_s1;
			p3_s2 <= qmul(p2_s1, s_s1);

			s_s3  <= s_s2;
			p2_s3 <= p2_s2;
			p3_s3 <= p3_s2;
			p4_s3 <= qmul(p3_s2, s_s2);

			p2_s4 <= p2_s3;
			p3_s4 <= p3_s3;
			p4_s4 <= p4_s3;
			p5_s4 <= qmul(p4_s3, s_s3);
		end
	end

	// Blend clamped to [0, 1.0] and rate polynomial clamped at zero.
	always_comb begin
		logic signed [BW-1:0] e2, e3, e4, e5, blend_w, poly_w;
		e2      = BW'(p2_s4);
		e3      = BW'(p3_s4);
		e4      = BW'(p4_s4);
		e5      = BW'(p5_s4);
		blend_w = K_B3 * e3 - K_B4 * e4 + K_B5 * e5;
		poly_w  = K_R2 * e2 - K_R3 * e3 + K_R4 * e4;
		if (blend_w < 0) begin
			blend_nx = '0;
		end else if (blend_w > ONE_X) begin
			blend_nx = QW'(ONE_Q);
		end else begin
			blend_nx = blend_w[QW-1:0];
		end
		poly_nx = (poly_w < 0) ? '0 : poly_w[PW-1:0];
	end

	// Scale both polynomials by |goal - start|.
	always_ff @(posedge clk) begin
		if (en) begin
			blend_s5 <= blend_nx;
			poly_s5  <= poly_nx;
			pprod_s6 <= PPW'(dmag_q) * PPW'(blend_s5);
			vprod_s6 <= VPW'(dmag_q) * VPW'(poly_s5);
		end
	end

	// Position add and saturation; split the velocity numerator for the divider.
	always_comb begin
		logic [W+1:0]        pmag;
		logic signed [W+2:0] pos_w;
		pmag  = pprod_s6[F +: W+2];
		pos_w = dneg_q ? ((W+3)'($signed(start_position_q)) - $signed({1'b0, pmag}))
			: ((W+3)'($signed(start_position_q)) + $signed({1'b0, pmag}));
		if (pos_w[W+2:W-1] == '0 || pos_w[W+2:W-1] == '1) begin
			pos_nx = pos_w[W-1:0];
		end else if (pos_w[W+2]) begin
			pos_nx = SAT_MIN;
		end else begin
			pos_nx = SAT_MAX;
		end
		vhi    = vprod_s6[W +: HW];
		ovf_nx = (CW'(vhi) >= CW'(den_q));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pos_s7 <= pos_nx;
			ovf_s7 <= ovf_nx;
			rem_s7 <= ovf_nx ? '0 : W'(vhi);
			low_s7 <= vprod_s6[W-1:0];
		end
	end

	// Velocity magnitude = numerator / duration; quotients of 2^W or more saturate.
	mjt_div_pipe #(
		.DEN_W  (W),
		.STEPS  (W),
		.SIDE_W (W + 1)
	) u_vel_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s7),
		.in_rem    (rem_s7),
		.in_bits   (low_s7),
		.in_side   ({pos_s7, ovf_s7}),
		.den       (den_q),
		.out_valid (vd_valid),
		.out_quo   (vd_quo),
		.out_side  (vd_side)
	);

	// Apply the sign of goal - start and saturate the velocity.
	always_comb begin
		if (vd_side[0]) begin
			vel_nx = dneg_q ? SAT_MIN : SAT_MAX;
		end else if (dneg_q) begin
			vel_nx = vd_quo[W-1] ? SAT_MIN : (W'(0) - vd_quo);
		end else begin
			vel_nx = vd_quo[W-1] ? SAT_MAX : vd_quo;
		end
	end

	// Output register.
	always_ff @(posedge clk) begin
		if (en) begin
			position_q <= vd_side[W:1];
			velocity_q <= vel_nx;
		end
	end

	assign result.valid        = out_valid_q;
	assign result.position_out = position_q;
	assign result.velocity_out = velocity_q;

endmodule

`default_nettype wire

// ===== src/mjt_checker.sv =====
`default_nettype none
`include "minimum_jerk_trajectory_top_macros.svh"

module mjt_checker #(
	parameter int unsigned DATA_WIDTH = mjt_pkg::DATA_WIDTH
) (
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  in_valid,
	input wire logic                  in_ready,
	input wire logic                  out_valid,
	input wire logic                  out_ready,
	input wire logic [DATA_WIDTH-1:0] position_out,
	input wire logic [DATA_WIDTH-1:0] velocity_out
);

	localparam int unsigned CNT_W = $clog2(2 * DATA_WIDTH + 64);

	logic [CNT_W-1:0] cnt_q;
	logic             in_beat;
	logic             out_beat;

	assign in_beat  = in_valid && in_ready;
	assign out_beat = out_valid && out_ready;

	// Samples accepted whose result beat has not been taken yet.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (in_beat && !out_beat) begin
			cnt_q <= cnt_q + CNT_W'(1);
		end else if (!in_beat && out_beat) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	`MJT_ASSERT_NEXT(a_stall_hold, out_valid && !out_ready, out_valid && $stable(position_out) && $stable(velocity_out), "stalled result beat changed or dropped")
	`MJT_ASSERT(a_ready_on_stall_only, !in_ready, out_valid && !out_ready, "input ready low without a stalled result")
	`MJT_ASSERT(a_no_orphan_result, out_valid, cnt_q != '0, "result beat with no sample outstanding")

endmodule

bind minimum_jerk_trajectory_top mjt_checker #(
	.DATA_WIDTH (DATA_WIDTH)
) u_mjt_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (sample.valid),
	.in_ready     (sample.ready),
	.out_valid    (result.valid),
	.out_ready    (result.ready),
	.position_out (result.position_out),
	.velocity_out (result.velocity_out)
);

`default_nettype wire

// ===== test/testbench.sv =====
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DW = mjt_pkg::DATA_WIDTH;
	localparam int FB = mjt_pkg::FRAC_BITS;
	localparam int IW = mjt_pkg::CFG_IDX_W;
	localparam int CLK_PERIOD = 10;
	localparam int RESET_CYCLES = 5;
	// Allowance for the pipeline from the default widths; it sizes the pressure test and the final wait.
	localparam int LATENCY = DW + FB + 8;
	localparam int HOLD_CYCLES = 400;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int RANDOM_PHASES = 10;
	localparam int SAMPLES_PER_PHASE = 40;
	// Enough samples to fill the whole pipeline while the output is held.
	localparam int PRESSURE_SAMPLES = 2 * LATENCY;

	// Index outside the register map; writes to it must change nothing.
	localparam logic [IW-1:0] REG_UNUSED = 2'd3;

	typedef longint unsigned u64_t;

	localparam u64_t ONE_Q = u64_t'(1) << FB;
	localparam longint POS_MAX = (longint'(1) << (DW - 1)) - 1;
	localparam longint NEG_MIN = -(longint'(1) << (DW - 1));

	typedef struct packed {
		logic signed [DW-1:0] position;
		logic signed [DW-1:0] velocity;
	} motion_t;

	// Shadow registers, motion predictor and the queue of expected beats.
	class motion_scoreboard;
		logic signed [DW-1:0] start_reg = '0;
		logic signed [DW-1:0] goal_reg = '0;
		logic [DW-1:0] duration_reg = DW'(ONE_Q);
		motion_t expected_motion[$];
		int mismatch_count = 0;

		task report(string what);
			$display("MISMATCH at %0t: %s", $time, what);
			mismatch_count++;
		endtask

		function void set_register(logic [IW-1:0] idx, logic [DW-1:0] value);
			case (idx)
				mjt_pkg::REG_START: start_reg = value;
				mjt_pkg::REG_GOAL: goal_reg = value;
				mjt_pkg::REG_DURATION: duration_reg = value;
				default: ;
			endcase
		endfunction

		function longint clamp_word(longint value);
			if (value > POS_MAX)
				return POS_MAX;
			if (value < NEG_MIN)
				return NEG_MIN;
			return value;
		endfunction

		function motion_t predict_motion(logic [DW-1:0] elapsed);
			u64_t span, phase, p2, p3, p4, p5, mag, scaled;
			longint blend, poly, base, diff, vel;
			motion_t m;
			// A zero duration behaves as one LSB.
			span = (duration_reg == '0) ? u64_t'(1) : u64_t'(duration_reg);
			// Phase is held at 1.0 once the trajectory has ended.
			if (u64_t'(elapsed) >= span)
				phase = ONE_Q;
			else
				phase = (u64_t'(elapsed) << FB) / span;
			p2 = (phase * phase) >> FB;
			p3 = (p2 * phase) >> FB;
			p4 = (p3 * phase) >> FB;
			p5 = (p4 * phase) >> FB;
			blend = mjt_pkg::COEF_BLEND3 * longint'(p3) - mjt_pkg::COEF_BLEND4 * longint'(p4)
				+ mjt_pkg::COEF_BLEND5 * longint'(p5);
			if (blend < 0)
				blend = 0;
			if (blend > longint'(ONE_Q))
				blend = longint'(ONE_Q);
			poly = mjt_pkg::COEF_RATE2 * longint'(p2) - mjt_pkg::COEF_RATE3 * longint'(p3)
				+ mjt_pkg::COEF_RATE4 * longint'(p4);
			if (poly < 0)
				poly = 0;
			// Work on the magnitude of the move so that rounding is toward zero.
			base = longint'(start_reg);
			diff = longint'(goal_reg) - base;
			if (diff < 0)
				mag = -diff;
			else
				mag = diff;
			scaled = (mag * u64_t'(blend)) >> FB;
			m.position = DW'(clamp_word(diff < 0 ? base - longint'(scaled)
				: base + longint'(scaled)));
			scaled = (mag * u64_t'(poly)) / span;
			vel = longint'(scaled);
			if (diff < 0)
				vel = -vel;
			m.velocity = DW'(clamp_word(vel));
			return m;
		endfunction

		function void note_sample(logic [DW-1:0] elapsed);
			expected_motion.insert(expected_motion.size(), predict_motion(elapsed));
		endfunction

		task check_result(logic signed [DW-1:0] position, logic signed [DW-1:0] velocity);
			motion_t m;
			if (expected_motion.size() == 0) begin
				report($sformatf("result beat pos=%0d vel=%0d with no sample pending",
					position, velocity));
				return;
			end
			m = expected_motion.pop_front();
			if (position !== m.position)
				report($sformatf("position %0d, expected %0d", position, m.position));
			if (velocity !== m.velocity)
				report($sformatf("velocity %0d, expected %0d", velocity, m.velocity));
		endtask

		function int pending();
			return expected_motion.size();
		endfunction

		task close_out();
			if (expected_motion.size() != 0)
				report($sformatf("%0d expected beats never arrived", expected_motion.size()));
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n;
	bit long_hold = 1'b0;
	int idle_cycles = 0;
	motion_scoreboard board = new();

	mjt_cfg_if cfg_bus();
	mjt_in_if sample_bus();
	mjt_out_if result_bus();

	minimum_jerk_trajectory_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_bus),
		.sample(sample_bus),
		.result(result_bus)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Register writes, accepted samples and result beats, seen at each rising edge.
	always @(posedge clk) begin
		if (arst_n === 1'b1) begin
			if (cfg_bus.valid && cfg_bus.ready)
				board.set_register(cfg_bus.index, cfg_bus.data);
			if (sample_bus.valid && sample_bus.ready)
				board.note_sample(sample_bus.elapsed_time);
			if (result_bus.valid && result_bus.ready)
				board.check_result(result_bus.position_out, result_bus.velocity_out);
		end
	end

	// Watchdog on cycles in which no beat moves on any channel.
	always @(posedge clk) begin
		if (arst_n === 1'b1) begin
			if ((cfg_bus.valid && cfg_bus.ready) || (sample_bus.valid && sample_bus.ready)
					|| (result_bus.valid && result_bus.ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles == WATCHDOG_LIMIT) begin
				$display("timeout: no beat moved for %0d cycles", WATCHDOG_LIMIT);
				$display("minimum_jerk_trajectory_top test failed");
				$finish;
			end
		end
	end

	// Result side: runs of steady, random, patterned and heavy stalls, plus one long hold.
	initial begin : result_stall
		int mode = 0;
		int run_left = 0;
		result_bus.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (long_hold) begin
				result_bus.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				long_hold = 1'b0;
			end else begin
				if (run_left == 0) begin
					mode = $urandom_range(0, 3);
					run_left = $urandom_range(8, 120);
				end
				run_left--;
				case (mode)
					0: result_bus.ready <= 1'b1;
					1: result_bus.ready <= 1'($urandom_range(0, 1));
					2: result_bus.ready <= (run_left % 4 != 0);
					default: result_bus.ready <= ($urandom_range(0, 4) == 0);
				endcase
			end
		end
	end

	// Offers one sample and returns at the edge where it is taken; valid stays high.
	task automatic send_sample(input logic [DW-1:0] elapsed);
		sample_bus.valid <= 1'b1;
		sample_bus.elapsed_time <= elapsed;
		do
			@(posedge clk);
		while (!sample_bus.ready);
	endtask

	// Writes one register and returns at the accepting edge; valid stays high.
	task automatic write_register(input logic [IW-1:0] idx, input logic [DW-1:0] value);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= idx;
		cfg_bus.data <= value;
		do
			@(posedge clk);
		while (!cfg_bus.ready);
	endtask

	task automatic program_trajectory(input logic [DW-1:0] start_pos, input logic [DW-1:0] goal_pos,
			input logic [DW-1:0] duration);
		write_register(mjt_pkg::REG_START, start_pos);
		write_register(mjt_pkg::REG_GOAL, goal_pos);
		write_register(mjt_pkg::REG_DURATION, duration);
		cfg_bus.valid <= 1'b0;
	endtask

	// Waits until every predicted beat has come back.
	task automatic wait_for_drain();
		while (board.pending() != 0)
			@(posedge clk);
	endtask

	task automatic send_directed(input logic [DW-1:0] times[$]);
		foreach (times[i])
			send_sample(times[i]);
		sample_bus.valid <= 1'b0;
	endtask

	function automatic logic [DW-1:0] pick_position();
		case ($urandom_range(0, 5))
			0: return {1'b1, {(DW - 1){1'b0}}};
			1: return {1'b0, {(DW - 1){1'b1}}};
			2: return DW'($urandom_range(0, 32'h0020_0000)) - DW'(32'h0010_0000);
			3: return '0;
			default: return $urandom();
		endcase
	endfunction

	// Random samples in bursts; a steady stream keeps valid high throughout.
	task automatic stream_samples(input int count, input bit steady);
		int burst_left;
		int gap;
		logic [DW-1:0] span;
		logic [DW-1:0] elapsed;
		burst_left = 0;
		for (int n = 0; n < count; n++) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 24);
				gap = steady ? 0 : ($urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 8));
				if (gap != 0) begin
					sample_bus.valid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
			span = (board.duration_reg == '0) ? DW'(1) : board.duration_reg;
			// Mostly times inside the move, with the end boundary and wide values mixed in.
			case ($urandom_range(0, 9))
				0: elapsed = $urandom();
				1: elapsed = '0;
				2: elapsed = span - 1'b1;
				3: elapsed = span;
				4: elapsed = (span == '1) ? span : span + 1'b1;
				5: elapsed = '1;
				default: elapsed = $urandom_range(0, span);
			endcase
			send_sample(elapsed);
			burst_left--;
		end
		sample_bus.valid <= 1'b0;
	endtask

	initial begin : stimulus
		logic [DW-1:0] duration;
		arst_n <= 1'b0;
		cfg_bus.valid <= 1'b0;
		cfg_bus.index <= mjt_pkg::REG_START;
		cfg_bus.data <= '0;
		sample_bus.valid <= 1'b0;
		sample_bus.elapsed_time <= '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Registers still at their reset values.
		send_directed('{32'h0000_0000, 32'h0000_8000, 32'hFFFF_FFFF});
		wait_for_drain();

		// Full-scale move over one second: velocity saturates in mid-move.
		program_trajectory(32'h8000_0000, 32'h7FFF_FFFF, 32'h0001_0000);
		send_directed('{32'h0000_0000, 32'h0000_0001, 32'h0000_4000, 32'h0000_8000,
			32'h0000_C000, 32'h0000_FFFF, 32'h0001_0000, 32'h0001_0001, 32'h7FFF_FFFF,
			32'h8000_0000, 32'hFFFF_FFFF});
		wait_for_drain();

		// Full-scale move downward over the shortest duration.
		program_trajectory(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001);
		send_directed('{32'h0000_0000, 32'h0000_0001, 32'h0000_0002});
		wait_for_drain();

		// A write to an unmapped index is dropped, and a zero duration acts as one LSB.
		write_register(REG_UNUSED, 32'h1234_5678);
		write_register(mjt_pkg::REG_DURATION, '0);
		cfg_bus.valid <= 1'b0;
		send_directed('{32'h0000_0000, 32'h0000_0001});
		wait_for_drain();

		// Longest duration.
		program_trajectory(32'h0000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
		send_directed('{32'h7FFF_FFFF, 32'hFFFF_FFFE, 32'hFFFF_FFFF});
		wait_for_drain();

		for (int phase_no = 0; phase_no < RANDOM_PHASES; phase_no++) begin
			case ($urandom_range(0, 5))
				0: duration = $urandom_range(1, 64);
				1: duration = 32'h0001_0000;
				2: duration = $urandom_range(32'h0000_1000, 32'h0010_0000);
				3: duration = '1;
				default: begin
					duration = $urandom();
					if (duration == '0)
						duration = 1;
				end
			endcase
			program_trajectory(pick_position(), pick_position(), duration);
			// One phase streams into a long output hold so the pipeline backs up.
			if (phase_no == 3)
				long_hold = 1'b1;
			stream_samples(phase_no == 3 ? PRESSURE_SAMPLES : SAMPLES_PER_PHASE,
				phase_no == 3);
			wait_for_drain();
		end

		// Any stray beat after the last expected one is caught here.
		repeat (LATENCY + 20) @(posedge clk);
		board.close_out();
		if (board.mismatch_count == 0)
			$display("minimum_jerk_trajectory_top test passed");
		else
			$display("minimum_jerk_trajectory_top test failed");
		$finish;
	end
endmodule
